>>> rtl/assert_macros.svh
// Assertion macros for the checker file of this block.
// No dependencies; the clocked macros expect clk_i in scope, and QG_ASSERT_RST also rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define QG_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that is also checked while reset is asserted.
`define QG_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> rtl/qgem_pkg.sv
// Shared types and constants for the quotient graph edge mapper.
// No dependencies; used by the top level and the port checker.
package qgem_pkg;

  // Sizes of the label store and the seen-pairs bitmap.
  localparam int unsigned MaxVertices = 1024;
  localparam int unsigned MaxGroups   = 64;
  localparam int unsigned VtxAw       = $clog2(MaxVertices);
  localparam int unsigned GrpAw       = $clog2(MaxGroups);

  // Configuration port widths and reset values.
  localparam int unsigned NumGroupsW = 7;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 7;
  localparam logic [NumGroupsW-1:0] NumGroupsReset = 7'd64;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_NUM_GROUPS = 2'd0,
    CFG_ALLOW_DUP  = 2'd1,
    CFG_ALLOW_SELF = 2'd2
  } cfg_reg_e;

  // Function codes of an input transaction.
  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_EDGE  = 2'd1,
    FUNC_CLEAR = 2'd2
  } func_e;

  // Input transaction payload.
  typedef struct packed {
    logic [1:0] func;
    logic [9:0] vertex;
    logic [9:0] neighbor;
    logic [5:0] label;
  } in_item_t;

  // Output transaction payload.
  typedef struct packed {
    logic [5:0] group;
    logic [5:0] neighbor_group;
  } out_item_t;

endpackage

>>> rtl/qgem_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies; width and depth come from the instance.
module qgem_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/quotient_graph_edge_mapper.sv
// Quotient graph edge mapper: takes one input transaction when in_ready_o is high. A load
// transaction, a clear transaction and an unused function code are handled in the idle state
// and give no result. An edge transaction steps through S_NBR, S_ROW and S_CHK, back to idle
// when the pair is dropped, and else through S_EMIT, where the result waits until the output
// register is empty or its pending result is taken by out_ready_i. No new transaction is taken
// before the block is back in idle. The single read port of the label memory reads the two
// vertex labels one after the other; the seen-pairs memory row is read and, when duplicates
// are not allowed, written back. Seen-pairs rows carry flip-flop valid flags, so reset and the
// clear transaction need no clearing pass. A never-loaded vertex reads as an undefined group.
module quotient_graph_edge_mapper (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [qgem_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [qgem_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  qgem_pkg::in_item_t          in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output qgem_pkg::out_item_t         out_data_o
);
  import qgem_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_NBR  = 5'b00010,
    S_ROW  = 5'b00100,
    S_CHK  = 5'b01000,
    S_EMIT = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [NumGroupsW-1:0] num_groups_q;
  logic                  allow_dup_q;
  logic                  allow_self_q;

  logic [VtxAw-1:0] nbr_q, nbr_d;
  logic [GrpAw-1:0] g_q, g_d;
  logic [GrpAw-1:0] ng_q, ng_d;
  logic [MaxGroups-1:0] row_valid_q, row_valid_d;

  logic             lbl_we, lbl_re;
  logic [VtxAw-1:0] lbl_raddr;
  logic [GrpAw-1:0] lbl_rdata;

  logic                 seen_we, seen_re;
  logic [MaxGroups-1:0] seen_rdata, seen_row, seen_wdata;
  logic                 drop;

  logic      out_valid_q, out_load;
  out_item_t out_data_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_groups_q <= NumGroupsReset;
      allow_dup_q  <= 1'b1;
      allow_self_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_NUM_GROUPS: num_groups_q <= cfg_data_i[NumGroupsW-1:0];
        CFG_ALLOW_DUP:  allow_dup_q  <= cfg_data_i[0];
        CFG_ALLOW_SELF: allow_self_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Label store: one group label per vertex.
  qgem_ram #(
    .Width(GrpAw),
    .Depth(MaxVertices)
  ) u_label_ram (
    .clk_i  (clk_i),
    .we_i   (lbl_we),
    .waddr_i(in_data_i.vertex[VtxAw-1:0]),
    .wdata_i(in_data_i.label[GrpAw-1:0]),
    .re_i   (lbl_re),
    .raddr_i(lbl_raddr),
    .rdata_o(lbl_rdata)
  );

  // Seen-pairs bitmap: one row of neighbor groups per source group.
  qgem_ram #(
    .Width(MaxGroups),
    .Depth(MaxGroups)
  ) u_seen_ram (
    .clk_i  (clk_i),
    .we_i   (seen_we),
    .waddr_i(g_q),
    .wdata_i(seen_wdata),
    .re_i   (seen_re),
    .raddr_i(g_q),
    .rdata_o(seen_rdata)
  );

  // A row without its valid flag reads as all zeros.
  assign seen_row   = row_valid_q[g_q] ? seen_rdata : '0;
  assign seen_wdata = seen_row | (MaxGroups'(1) << ng_q);
  assign drop       = (!allow_self_q && (g_q == ng_q)) || (!allow_dup_q && seen_row[ng_q]);

  assign in_ready_o = (state_q == S_IDLE);

  // Sequencer: loads and clears, label reads, bitmap read-modify-write, then result handoff.
  always_comb begin
    state_d     = state_q;
    nbr_d       = nbr_q;
    g_d         = g_q;
    ng_d        = ng_q;
    row_valid_d = row_valid_q;
    lbl_we      = 1'b0;
    lbl_re      = 1'b0;
    lbl_raddr   = in_data_i.vertex[VtxAw-1:0];
    seen_we     = 1'b0;
    seen_re     = 1'b0;
    out_load    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (in_data_i.func)
            FUNC_LOAD: lbl_we = 1'b1;
            FUNC_EDGE: begin
              lbl_re  = 1'b1;
              nbr_d   = in_data_i.neighbor[VtxAw-1:0];
              state_d = S_NBR;
            end
            FUNC_CLEAR: begin
              for (int r = 0; r < MaxGroups; r++) begin
                if (NumGroupsW'(r) < num_groups_q) begin
                  row_valid_d[r] = 1'b0;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_NBR: begin
        g_d       = lbl_rdata;
        lbl_re    = 1'b1;
        lbl_raddr = nbr_q;
        state_d   = S_ROW;
      end
      S_ROW: begin
        ng_d    = lbl_rdata;
        seen_re = 1'b1;
        state_d = S_CHK;
      end
      S_CHK: begin
        if (drop) begin
          state_d = S_IDLE;
        end else begin
          if (!allow_dup_q) begin
            seen_we          = 1'b1;
            row_valid_d[g_q] = 1'b1;
          end
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      row_valid_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_valid_q <= row_valid_d;
      out_valid_q <= out_load | (out_valid_q & ~out_ready_i);
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    nbr_q <= nbr_d;
    g_q   <= g_d;
    ng_q  <= ng_d;
    if (out_load) begin
      out_data_q.group          <= 6'(g_q);
      out_data_q.neighbor_group <= 6'(ng_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

>>> rtl/qgem_checker.sv
// Port-level checker for the quotient graph edge mapper, bound to the top level.
// Depends on qgem_pkg and assert_macros.svh.
`include "assert_macros.svh"

module qgem_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input qgem_pkg::in_item_t            in_data_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input qgem_pkg::out_item_t           out_data_o
);
  import qgem_pkg::*;

  logic in_fire, edge_fire;

  assign in_fire   = in_valid_i && in_ready_o;
  assign edge_fire = in_fire && (in_data_i.func == FUNC_EDGE);

  // A pending result holds until it is taken.
  `QG_ASSERT_RST(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o), "output transaction changed while stalled")

  // A clock edge under reset leaves no result pending in the next cycle.
  `QG_ASSERT_ALWAYS(a_out_reset, !rst_ni |=> !out_valid_o, "output valid after a reset cycle")

  // An edge transaction keeps the block busy in the following cycle.
  `QG_ASSERT_RST(a_edge_busy, edge_fire |=> !in_ready_o, "ready right after an edge transaction")

  // Load, clear and unused transactions never raise a result.
  `QG_ASSERT_RST(a_no_spurious, in_fire && !edge_fire && !out_valid_o |=> !out_valid_o, "result after a non-edge transaction")

endmodule

bind quotient_graph_edge_mapper qgem_checker u_qgem_checker (.*);
